/* hdl/afc_pkg.sv */
// Shared types, constants and helpers for the frustum culling block.
`timescale 1ns / 1ps

package afc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int COORD_W        = 32;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = COORD_W + DIFF_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int PASSED_W       = 3;
  localparam int IDX_IN_W       = 3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TEST  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } afc_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
  } afc_plane_t;

  typedef struct packed {
    logic write_plane;
    logic capture_box;
    logic issue;
    logic flush;
  } afc_cmd_t;

  typedef struct packed {
    logic res_valid;
    logic res_neg;
  } afc_status_t;

  // Positive vertex on one axis minus the plane point, exact in 33 bits.
  function automatic logic signed [DIFF_W-1:0] vertex_diff(
    input logic [COORD_W-1:0] n,
    input logic [COORD_W-1:0] mn,
    input logic [COORD_W-1:0] mx,
    input logic [COORD_W-1:0] p
  );
    logic [COORD_W-1:0]      v;
    logic signed [DIFF_W-1:0] vs;
    logic signed [DIFF_W-1:0] ps;
    v  = n[COORD_W-1] ? mn : mx;
    vs = {v[COORD_W-1], v};
    ps = {p[COORD_W-1], p};
    return vs - ps;
  endfunction

endpackage

/* hdl/afc_datapath.sv */
// Plane table, box registers and the pipelined dot-product sign unit.
`timescale 1ns / 1ps

module afc_datapath
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF,
  parameter int IDX_W      = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afc_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]    issue_idx_i,
  input  logic [IDX_IN_W-1:0] plane_index_i,
  input  logic [COORD_W-1:0]  a_x_i,
  input  logic [COORD_W-1:0]  a_y_i,
  input  logic [COORD_W-1:0]  a_z_i,
  input  logic [COORD_W-1:0]  b_x_i,
  input  logic [COORD_W-1:0]  b_y_i,
  input  logic [COORD_W-1:0]  b_z_i,
  output afc_status_t         status_o
);

  afc_plane_t                plane_q [NUM_PLANES];
  logic [NUM_PLANES-1:0]     pvalid_q;
  logic [COORD_W-1:0]        min_x_q, min_y_q, min_z_q;
  logic [COORD_W-1:0]        max_x_q, max_y_q, max_z_q;

  afc_plane_t                ent;
  logic signed [DIFF_W-1:0]  dx_d, dy_d, dz_d;
  logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q;
  logic signed [COORD_W-1:0] nx_q, ny_q, nz_q;
  logic signed [PROD_W-1:0]  px_d, py_d, pz_d;
  logic signed [PROD_W-1:0]  px_q, py_q, pz_q;
  logic signed [SUM_W-1:0]   sum;
  logic                      v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= '0;
    end else if (cmd_i.write_plane) begin
      for (int e = 0; e < NUM_PLANES; e++) begin
        if (32'(plane_index_i) == e) begin
          pvalid_q[e] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_plane) begin
      for (int e = 0; e < NUM_PLANES; e++) begin
        if (32'(plane_index_i) == e) begin
          plane_q[e] <= '{nx: a_x_i, ny: a_y_i, nz: a_z_i,
                          px: b_x_i, py: b_y_i, pz: b_z_i};
        end
      end
    end
    if (cmd_i.capture_box) begin
      min_x_q <= a_x_i;
      min_y_q <= a_y_i;
      min_z_q <= a_z_i;
      max_x_q <= b_x_i;
      max_y_q <= b_y_i;
      max_z_q <= b_z_i;
    end
  end

  always_comb begin
    ent  = pvalid_q[issue_idx_i] ? plane_q[issue_idx_i] : '0;
    dx_d = vertex_diff(ent.nx, min_x_q, max_x_q, ent.px);
    dy_d = vertex_diff(ent.ny, min_y_q, max_y_q, ent.py);
    dz_d = vertex_diff(ent.nz, min_z_q, max_z_q, ent.pz);
  end

  assign px_d = nx_q * dx_q;
  assign py_d = ny_q * dy_q;
  assign pz_d = nz_q * dz_q;
  assign sum  = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q);

  always_ff @(posedge clk_i) begin
    nx_q <= ent.nx;
    ny_q <= ent.ny;
    nz_q <= ent.nz;
    dx_q <= dx_d;
    dy_q <= dy_d;
    dz_q <= dz_d;
    px_q <= px_d;
    py_q <= py_d;
    pz_q <= pz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue & ~cmd_i.flush;
      v2_q <= v1_q & ~cmd_i.flush;
    end
  end

  assign status_o.res_valid = v2_q;
  assign status_o.res_neg   = sum[SUM_W-1];

endmodule

/* hdl/afc_ctrl.sv */
// Controller: transaction handshakes, plane sequencing, pass count and result register.
`timescale 1ns / 1ps

module afc_ctrl
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF,
  parameter int IDX_W      = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 visible_o,
  output logic [PASSED_W-1:0]  planes_passed_o,
  output afc_cmd_t             cmd_o,
  output logic [IDX_W-1:0]     issue_idx_o,
  input  afc_status_t          status_i
);

  localparam int CNT_MIN = $clog2(NUM_PLANES + 1);
  localparam int CNT_W   = (CNT_MIN > PASSED_W) ? CNT_MIN : PASSED_W;

  afc_state_e       state_q, state_d;
  logic [CNT_W-1:0] issue_cnt_q, issue_cnt_d;
  logic [CNT_W-1:0] pass_cnt_q, pass_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             visible_q, visible_d;
  logic [PASSED_W-1:0] passed_q, passed_d;
  logic             out_free;
  logic             done;
  logic             load;
  logic [CNT_W-1:0] pass_inc;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pass_inc = pass_cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_cnt_q <= '0;
      pass_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      pass_cnt_q  <= pass_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= visible_d;
    passed_q  <= passed_d;
  end

  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    pass_cnt_d  = pass_cnt_q;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    done        = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (mode_i == MODE_TEST) begin
            cmd_o.capture_box = 1'b1;
            issue_cnt_d       = '0;
            pass_cnt_d        = '0;
            state_d           = ST_RUN;
          end else begin
            cmd_o.write_plane = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (issue_cnt_q < CNT_W'(NUM_PLANES)) begin
          cmd_o.issue = 1'b1;
          issue_cnt_d = issue_cnt_q + CNT_W'(1);
        end
        if (status_i.res_valid) begin
          if (status_i.res_neg) begin
            done = 1'b1;
          end else begin
            pass_cnt_d = pass_inc;
            if (pass_inc == CNT_W'(NUM_PLANES)) begin
              done = 1'b1;
            end
          end
        end
        if (done) begin
          cmd_o.flush = 1'b1;
          if (out_free) begin
            load    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    visible_d   = visible_q;
    passed_d    = passed_q;
    if (load) begin
      out_valid_d = 1'b1;
      visible_d   = (pass_cnt_d == CNT_W'(NUM_PLANES));
      passed_d    = pass_cnt_d[PASSED_W-1:0];
    end
  end

  assign issue_idx_o     = issue_cnt_q[IDX_W-1:0];
  assign out_valid_o     = out_valid_q;
  assign visible_o       = visible_q;
  assign planes_passed_o = passed_q;

endmodule

/* hdl/aabb_frustum_cull.sv */
// A box test exits early on rejection and ends at the first plane with a negative dot product.
// Inputs stall until the result is loaded; while a box runs, one plane per cycle passes the
// three-stage dot-product unit (read and subtract, multiply, sum and sign).
// A plane write gives no result.
// Reset (rst_ni low, asynchronous) marks every plane slot empty, so it reads as zero.
`timescale 1ns / 1ps

module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [IDX_IN_W-1:0] plane_index_i,
  input  logic [COORD_W-1:0]  a_x_i,
  input  logic [COORD_W-1:0]  a_y_i,
  input  logic [COORD_W-1:0]  a_z_i,
  input  logic [COORD_W-1:0]  b_x_i,
  input  logic [COORD_W-1:0]  b_y_i,
  input  logic [COORD_W-1:0]  b_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                visible_o,
  output logic [PASSED_W-1:0] planes_passed_o
);

  localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  afc_cmd_t         cmd;
  afc_status_t      status;
  logic [IDX_W-1:0] issue_idx;

  afc_ctrl #(
    .NUM_PLANES (NUM_PLANES),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .visible_o       (visible_o),
    .planes_passed_o (planes_passed_o),
    .cmd_o           (cmd),
    .issue_idx_o     (issue_idx),
    .status_i        (status)
  );

  afc_datapath #(
    .NUM_PLANES (NUM_PLANES),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .issue_idx_i   (issue_idx),
    .plane_index_i (plane_index_i),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .a_z_i         (a_z_i),
    .b_x_i         (b_x_i),
    .b_y_i         (b_y_i),
    .b_z_i         (b_z_i),
    .status_o      (status)
  );

endmodule

/* hdl/afc_checker.sv */
// Port-level assertions for the frustum culling block, bound to its top level.
`timescale 1ns / 1ps

module afc_checker
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                mode_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                visible_o,
  input logic [PASSED_W-1:0] planes_passed_o
);

  localparam logic [PASSED_W-1:0] ALL_PASSED = PASSED_W'(NUM_PLANES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o)
      && $stable(planes_passed_o))
    else $error("stalled result transaction changed");

  a_visible_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> planes_passed_o == ALL_PASSED)
    else $error("visible result without a full plane count");

  a_reject_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NUM_PLANES < 8) && out_valid_o && !visible_o |-> planes_passed_o != ALL_PASSED)
    else $error("rejected result with a full plane count");

  a_box_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_TEST) |=> in_stall_o)
    else $error("input taken while a box is under test");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_WRITE) && !out_valid_o |=> !out_valid_o)
    else $error("plane write produced a result");

endmodule

bind aabb_frustum_cull afc_checker #(
  .NUM_PLANES (NUM_PLANES)
) u_afc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .mode_i          (mode_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .visible_o       (visible_o),
  .planes_passed_o (planes_passed_o)
);

/* bench/tb.sv */
// Self-checking bench for aabb_frustum_cull: plane writes and box tests against a local predictor.
`timescale 1ns / 1ps

module tb
  import afc_pkg::*;
();

  localparam int NPL = NUM_PLANES_DEF;

  typedef struct packed {
    logic                         mode;
    logic [IDX_IN_W-1:0]          idx;
    logic [2:0][COORD_W-1:0]      a;
    logic [2:0][COORD_W-1:0]      b;
    logic                         drain;
  } cull_txn_t;

  typedef struct packed {
    logic                visible;
    logic [PASSED_W-1:0] passed;
  } cull_verdict_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                mode_i          = MODE_WRITE;
  logic [IDX_IN_W-1:0] plane_index_i   = '0;
  logic [COORD_W-1:0]  a_x_i           = '0;
  logic [COORD_W-1:0]  a_y_i           = '0;
  logic [COORD_W-1:0]  a_z_i           = '0;
  logic [COORD_W-1:0]  b_x_i           = '0;
  logic [COORD_W-1:0]  b_y_i           = '0;
  logic [COORD_W-1:0]  b_z_i           = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b1;
  logic                visible_o;
  logic [PASSED_W-1:0] planes_passed_o;

  cull_txn_t     pending_q[$];
  cull_verdict_t verdict_q[$];
  afc_plane_t    frustum[NPL];
  cull_txn_t     cur;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            mismatches    = 0;

  aabb_frustum_cull dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .plane_index_i   (plane_index_i),
    .a_x_i           (a_x_i),
    .a_y_i           (a_y_i),
    .a_z_i           (a_z_i),
    .b_x_i           (b_x_i),
    .b_y_i           (b_y_i),
    .b_z_i           (b_z_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .visible_o       (visible_o),
    .planes_passed_o (planes_passed_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [66:0] axis_term(input logic [COORD_W-1:0] n,
                                                   input logic [COORD_W-1:0] mn,
                                                   input logic [COORD_W-1:0] mx,
                                                   input logic [COORD_W-1:0] p);
    logic signed [66:0] nw;
    logic signed [66:0] dw;
    nw = $signed(n);
    dw = $signed(n[COORD_W-1] ? mn : mx) - $signed(p);
    return nw * dw;
  endfunction

  task automatic predict_cull(input cull_txn_t t);
    logic signed [66:0] acc;
    int                 hits;
    logic               rejected;
    cull_verdict_t      v;
    if (t.mode == MODE_WRITE) begin
      if (t.idx < NPL) begin
        frustum[t.idx].nx = t.a[0];
        frustum[t.idx].ny = t.a[1];
        frustum[t.idx].nz = t.a[2];
        frustum[t.idx].px = t.b[0];
        frustum[t.idx].py = t.b[1];
        frustum[t.idx].pz = t.b[2];
      end
    end else begin
      hits     = 0;
      rejected = 1'b0;
      for (int i = 0; i < NPL; i++) begin
        acc = axis_term(frustum[i].nx, t.a[0], t.b[0], frustum[i].px)
            + axis_term(frustum[i].ny, t.a[1], t.b[1], frustum[i].py)
            + axis_term(frustum[i].nz, t.a[2], t.b[2], frustum[i].pz);
        if (!rejected) begin
          if (acc < 0) rejected = 1'b1;
          else hits++;
        end
      end
      v.visible = (hits == NPL);
      v.passed  = hits[PASSED_W-1:0];
      verdict_q.insert(verdict_q.size(), v);
    end
  endtask

  task automatic note_mismatch(input string what, input cull_verdict_t want);
    if (mismatches < 10) begin
      $display("%0t: %s: expected visible=%0b passed=%0d, got visible=%0b passed=%0d",
               $realtime, what, want.visible, want.passed, visible_o, planes_passed_o);
    end
    mismatches++;
  endtask

  task automatic push_txn(input logic mode, input logic [IDX_IN_W-1:0] idx,
                          input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                          input logic [COORD_W-1:0] az, input logic [COORD_W-1:0] bx,
                          input logic [COORD_W-1:0] by, input logic [COORD_W-1:0] bz);
    cull_txn_t t;
    t.mode  = mode;
    t.idx   = idx;
    t.a     = {az, ay, ax};
    t.b     = {bz, by, bx};
    t.drain = ($urandom_range(99) == 0);
    pending_q.insert(pending_q.size(), t);
  endtask

  function automatic logic [COORD_W-1:0] rand_q(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(2 * lim * 65536);
    return r - lim * 65536;
  endfunction

  function automatic logic [COORD_W-1:0] rand_wild();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_normal();
    return ($urandom_range(7) == 0) ? '0 : rand_q(1);
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n);
    int          count;
    int unsigned pick;
    logic [COORD_W-1:0] c[3];
    logic [COORD_W-1:0] h[3];
    logic [IDX_IN_W-1:0] idx;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        for (int i = 0; i < NPL; i++) begin
          push_txn(MODE_WRITE, IDX_IN_W'(i), rand_normal(), rand_normal(), rand_normal(),
                   rand_q(40), rand_q(40), rand_q(40));
        end
        count += NPL;
      end else if (pick < 14) begin
        idx = IDX_IN_W'($urandom_range(7));
        push_txn(MODE_WRITE, idx, rand_wild(), rand_wild(), rand_wild(),
                 rand_wild(), rand_wild(), rand_wild());
        if (idx < NPL) count++;
      end else if (pick < 24) begin
        push_txn(MODE_TEST, IDX_IN_W'($urandom_range(7)), rand_wild(), rand_wild(),
                 rand_wild(), rand_wild(), rand_wild(), rand_wild());
        count++;
      end else begin
        for (int k = 0; k < 3; k++) begin
          c[k] = rand_q(60);
          h[k] = $urandom_range(20 * 65536);
        end
        if ($urandom_range(9) == 0) begin
          push_txn(MODE_TEST, IDX_IN_W'($urandom_range(7)),
                   c[0] + h[0], c[1] + h[1], c[2] + h[2],
                   c[0] - h[0], c[1] - h[1], c[2] - h[2]);
        end else begin
          push_txn(MODE_TEST, IDX_IN_W'($urandom_range(7)),
                   c[0] - h[0], c[1] - h[1], c[2] - h[2],
                   c[0] + h[0], c[1] + h[1], c[2] + h[2]);
        end
        count++;
      end
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) predict_cull(cur);
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_q[0].drain && verdict_q.size() != 0)) begin
          cur = pending_q.pop_front();
          in_valid_i    <= 1'b1;
          mode_i        <= cur.mode;
          plane_index_i <= cur.idx;
          a_x_i         <= cur.a[0];
          a_y_i         <= cur.a[1];
          a_z_i         <= cur.a[2];
          b_x_i         <= cur.b[0];
          b_y_i         <= cur.b[1];
          b_z_i         <= cur.b[2];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cull_verdict_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result", want);
        end else begin
          want = verdict_q.pop_front();
          if (visible_o !== want.visible || planes_passed_o !== want.passed) begin
            note_mismatch("result mismatch", want);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    for (int i = 0; i < NPL; i++) frustum[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extreme and inverted boxes
    push_txn(MODE_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_TEST, 7, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_txn(MODE_WRITE, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    // out-of-range slots
    push_txn(MODE_WRITE, 6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_WRITE, 7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_TEST, 0, '0, '0, '0, '0, '0, '0);
    // zero dot product passes, one unit below rejects
    push_txn(MODE_WRITE, 5, 32'h0001_0000, '0, '0, '0, '0, '0);
    push_txn(MODE_TEST, 0, 32'hfffb_0000, '0, '0, '0, '0, '0);
    push_txn(MODE_TEST, 0, 32'hfffb_0000, '0, '0, 32'hffff_ffff, '0, '0);
    // widest accumulator sums
    push_txn(MODE_WRITE, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0);
    push_txn(MODE_TEST, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0, '0);
    push_txn(MODE_WRITE, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_txn(MODE_TEST, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_WRITE, 2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_WRITE, 1, '0, '0, '0, '0, '0, '0);
    push_txn(MODE_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_txn(MODE_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_txn(MODE_WRITE, 3, '0, 32'hffff_0000, '0, '0, 32'h0010_0000, '0);
    push_txn(MODE_WRITE, 4, '0, '0, 32'h0001_0000, '0, '0, 32'hfff0_0000);
    push_txn(MODE_TEST, 0, '0, 32'h0011_0000, 32'hffe0_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'hffe8_0000);
    push_txn(MODE_TEST, 0, '0, 32'h0008_0000, 32'hffe0_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'hffe8_0000);

    run_phase(21, 83, 400);
    run_phase(83, 21, 400);
    run_phase(0, 0, 400);

    repeat (NPL + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
